### hw/rtl/half_duplex_uart_fifo_controller_defines.svh
// Assertion macros shared by the checker of the serial link controller.
`ifndef HALF_DUPLEX_UART_FIFO_CONTROLLER_DEFINES_SVH
`define HALF_DUPLEX_UART_FIFO_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HDUF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hduf assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HDUF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hduf assertion failed");

// Next-cycle implication that also holds across reset.
`define HDUF_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hduf assertion failed");

`endif

### hw/rtl/hduf_pkg.sv
// Types, codes and constants of the half-duplex serial link controller.
package hduf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LEVEL_W = 5;
    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        REQ_WRITE   = 3'd0,
        REQ_READ    = 3'd1,
        REQ_TX_ON   = 3'd2,
        REQ_TX_OFF  = 3'd3,
        REQ_RX_ON   = 3'd4,
        REQ_RX_OFF  = 3'd5,
        REQ_RX_DONE = 3'd6,
        REQ_TX_DONE = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } t_mode;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_RX = 2'd1;
    localparam logic [1:0] CMD_TX = 2'd2;

    typedef enum logic {
        PIPE_READY = 1'b0,
        PIPE_FETCH = 1'b1
    } t_pipe;

    typedef struct packed {
        logic [1:0] abort_cmd;
        logic [1:0] start_cmd;
        logic       read_valid;
        logic       write_accepted;
        logic       tx_pop;
        logic       tx_fwd;
        logic       rx_pop;
    } t_step;

    typedef struct packed {
        t_mode              mode;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic               rx_on;
        logic               tx_on;
    } t_status;

    typedef struct packed {
        logic [1:0]         abort_cmd;
        logic [1:0]         start_cmd;
        logic [BYTE_W-1:0]  tx_byte;
        logic [BYTE_W-1:0]  read_byte;
        logic               read_valid;
        logic               write_accepted;
        logic [1:0]         link_mode;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic               rx_on;
        logic               tx_on;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

### hw/rtl/hduf_if.sv
// Request and result channel interfaces of the serial link controller.
interface hduf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink (input valid, input req_type, input data_in, output ready);
endinterface

interface hduf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] abort_cmd;
    logic [1:0] start_cmd;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_accepted;
    logic [1:0] link_mode;
    logic [4:0] rx_level;
    logic [4:0] tx_level;
    logic       rx_on;
    logic       tx_on;

    modport source (
        output valid, output abort_cmd, output start_cmd, output tx_byte,
        output read_byte, output read_valid, output write_accepted,
        output link_mode, output rx_level, output tx_level, output rx_on,
        output tx_on, input ready
    );
    modport sink (
        input valid, input abort_cmd, input start_cmd, input tx_byte,
        input read_byte, input read_valid, input write_accepted,
        input link_mode, input rx_level, input tx_level, input rx_on,
        input tx_on, output ready
    );
endinterface

### hw/rtl/hduf_ram.sv
// Byte queue storage: one write port and one registered read port.
module hduf_ram import hduf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]              i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]              o_rdata
);

    logic [BYTE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/hduf_ctrl.sv
// Link mode, enable flags and queue pointers, updated once per accepted request.
module hduf_ctrl import hduf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  t_req                           i_req_type,
    input  logic [BYTE_W-1:0]              i_data_in,
    output t_step                          o_step,
    output t_status                        o_status,
    output logic                           o_tx_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_tx_waddr,
    output logic                           o_tx_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_tx_raddr,
    output logic                           o_rx_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rx_waddr,
    output logic                           o_rx_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rx_raddr,
    output logic [BYTE_W-1:0]              o_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_mode          r_mode, n_mode;
    logic           r_rx_en, n_rx_en;
    logic           r_tx_en, n_tx_en;
    logic [AW-1:0]  r_tx_head, n_tx_head;
    logic [AW-1:0]  r_rx_head, n_rx_head;
    logic [CW-1:0]  r_tx_cnt, n_tx_cnt;
    logic [CW-1:0]  r_rx_cnt, n_rx_cnt;

    t_step          step;
    logic           tx_push;
    logic           rx_push;
    logic           do_tx_on;
    logic           tx_full;
    logic           rx_full;
    logic [AW:0]    tx_wsum;
    logic [AW:0]    rx_wsum;

    assign tx_full = (r_tx_cnt == CW'(QUEUE_DEPTH));
    assign rx_full = (r_rx_cnt == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_rx_en   <= 1'b0;
            r_tx_en   <= 1'b0;
            r_tx_head <= '0;
            r_rx_head <= '0;
            r_tx_cnt  <= '0;
            r_rx_cnt  <= '0;
        end else begin
            r_mode    <= n_mode;
            r_rx_en   <= n_rx_en;
            r_tx_en   <= n_tx_en;
            r_tx_head <= n_tx_head;
            r_rx_head <= n_rx_head;
            r_tx_cnt  <= n_tx_cnt;
            r_rx_cnt  <= n_rx_cnt;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_rx_en  = r_rx_en;
        n_tx_en  = r_tx_en;
        step     = '0;
        tx_push  = 1'b0;
        rx_push  = 1'b0;
        do_tx_on = 1'b0;
        if (i_fire) begin
            unique case (i_req_type)
                REQ_WRITE: begin
                    tx_push = !tx_full;
                    step.write_accepted = !tx_full;
                    do_tx_on = r_tx_en;
                end
                REQ_READ: begin
                    if (r_rx_cnt != '0) begin
                        step.rx_pop = 1'b1;
                        step.read_valid = 1'b1;
                    end
                end
                REQ_TX_ON: begin
                    do_tx_on = 1'b1;
                end
                REQ_TX_OFF: begin
                    n_tx_en = 1'b0;
                    if (r_mode == MODE_TX) begin
                        step.abort_cmd = CMD_TX;
                        n_mode = MODE_IDLE;
                    end
                end
                REQ_RX_ON: begin
                    n_rx_en = 1'b1;
                    if (r_mode != MODE_RX) begin
                        if (r_mode == MODE_TX) begin
                            step.abort_cmd = CMD_TX;
                        end
                        step.start_cmd = CMD_RX;
                        n_mode = MODE_RX;
                    end
                end
                REQ_RX_OFF: begin
                    n_rx_en = 1'b0;
                    if (r_mode == MODE_RX) begin
                        step.abort_cmd = CMD_RX;
                        n_mode = MODE_IDLE;
                    end
                end
                REQ_RX_DONE: begin
                    if (r_mode == MODE_RX) begin
                        if (!rx_full) begin
                            rx_push = 1'b1;
                            step.start_cmd = CMD_RX;
                        end else begin
                            step.abort_cmd = CMD_RX;
                            n_rx_en = 1'b0;
                            n_mode = MODE_IDLE;
                        end
                    end
                end
                REQ_TX_DONE: begin
                    if (r_mode == MODE_TX) begin
                        if (r_tx_cnt != '0) begin
                            step.tx_pop = 1'b1;
                            step.start_cmd = CMD_TX;
                        end else if (r_rx_en && !rx_full) begin
                            step.start_cmd = CMD_RX;
                            n_mode = MODE_RX;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // Turning transmit on also follows a host write while transmit is enabled.
        if (do_tx_on) begin
            n_tx_en = 1'b1;
            if (r_mode != MODE_TX) begin
                if (r_mode == MODE_RX) begin
                    step.abort_cmd = CMD_RX;
                    n_mode = MODE_IDLE;
                end
                if ((r_tx_cnt != '0) || tx_push) begin
                    step.tx_pop = 1'b1;
                    step.tx_fwd = (r_tx_cnt == '0);
                    step.start_cmd = CMD_TX;
                    n_mode = MODE_TX;
                end
            end
        end
    end

    always_comb begin
        tx_wsum = {1'b0, r_tx_head} + (AW + 1)'(r_tx_cnt);
        if (tx_wsum >= (AW + 1)'(QUEUE_DEPTH)) begin
            tx_wsum = tx_wsum - (AW + 1)'(QUEUE_DEPTH);
        end
        rx_wsum = {1'b0, r_rx_head} + (AW + 1)'(r_rx_cnt);
        if (rx_wsum >= (AW + 1)'(QUEUE_DEPTH)) begin
            rx_wsum = rx_wsum - (AW + 1)'(QUEUE_DEPTH);
        end
    end

    always_comb begin
        n_tx_head = r_tx_head;
        n_rx_head = r_rx_head;
        if (step.tx_pop) begin
            n_tx_head = (r_tx_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
        end
        if (step.rx_pop) begin
            n_rx_head = (r_rx_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
        end
        n_tx_cnt = r_tx_cnt + CW'(tx_push) - CW'(step.tx_pop);
        n_rx_cnt = r_rx_cnt + CW'(rx_push) - CW'(step.rx_pop);
    end

    assign o_step = step;
    assign o_status.mode = n_mode;
    assign o_status.rx_level = LEVEL_W'(n_rx_cnt);
    assign o_status.tx_level = LEVEL_W'(n_tx_cnt);
    assign o_status.rx_on = n_rx_en;
    assign o_status.tx_on = n_tx_en;

    assign o_tx_we = tx_push;
    assign o_tx_waddr = AW'(tx_wsum);
    assign o_tx_re = step.tx_pop && !step.tx_fwd;
    assign o_tx_raddr = r_tx_head;
    assign o_rx_we = rx_push;
    assign o_rx_waddr = AW'(rx_wsum);
    assign o_rx_re = step.rx_pop;
    assign o_rx_raddr = r_rx_head;
    assign o_wdata = i_data_in;

endmodule

### hw/rtl/half_duplex_uart_fifo_controller.sv
// Top level of the half-duplex serial link controller with transmit and receive queues.
// Each request yields exactly one result. When a request is taken, mode, flags and queue
// pointers are updated and the queue memory read is issued; the result is loaded into the
// output register in the FETCH state, once the registered memory read has returned and the
// output register is empty or being read. No new request is taken until the result of the
// last one is loaded, and a result waiting in the output register holds back at most one
// more request. Queue contents need no clearing after reset.
module half_duplex_uart_fifo_controller import hduf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hduf_req_if.sink   i_req,
    hduf_res_if.source o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_pipe             r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_result           r_res;
    t_step             r_step;
    t_status           r_status;
    logic [BYTE_W-1:0] r_fwd_byte;

    logic              fire;
    logic              load_out;
    t_step             step;
    t_status           status;
    logic              tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0]     tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    assign i_req.ready = (r_state == PIPE_READY);
    assign fire = i_req.valid && i_req.ready;

    hduf_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req_type (t_req'(i_req.req_type)),
        .i_data_in  (i_req.data_in),
        .o_step     (step),
        .o_status   (status),
        .o_tx_we    (tx_we),
        .o_tx_waddr (tx_waddr),
        .o_tx_re    (tx_re),
        .o_tx_raddr (tx_raddr),
        .o_rx_we    (rx_we),
        .o_rx_waddr (rx_waddr),
        .o_rx_re    (rx_re),
        .o_rx_raddr (rx_raddr),
        .o_wdata    (wdata)
    );

    hduf_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (wdata),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    hduf_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (wdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PIPE_READY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        load_out = 1'b0;
        unique case (r_state)
            PIPE_READY: begin
                if (fire) begin
                    n_state = PIPE_FETCH;
                end
            end
            PIPE_FETCH: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state = PIPE_READY;
                end
            end
            default: begin
                n_state = PIPE_READY;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_step     <= step;
            r_status   <= status;
            r_fwd_byte <= i_req.data_in;
        end
        if (load_out) begin
            r_res.abort_cmd      <= r_step.abort_cmd;
            r_res.start_cmd      <= r_step.start_cmd;
            r_res.tx_byte        <= !r_step.tx_pop ? '0 :
                                    (r_step.tx_fwd ? r_fwd_byte : tx_rdata);
            r_res.read_byte      <= r_step.rx_pop ? rx_rdata : '0;
            r_res.read_valid     <= r_step.read_valid;
            r_res.write_accepted <= r_step.write_accepted;
            r_res.link_mode      <= r_status.mode;
            r_res.rx_level       <= r_status.rx_level;
            r_res.tx_level       <= r_status.tx_level;
            r_res.rx_on          <= r_status.rx_on;
            r_res.tx_on          <= r_status.tx_on;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.abort_cmd      = r_res.abort_cmd;
    assign o_res.start_cmd      = r_res.start_cmd;
    assign o_res.tx_byte        = r_res.tx_byte;
    assign o_res.read_byte      = r_res.read_byte;
    assign o_res.read_valid     = r_res.read_valid;
    assign o_res.write_accepted = r_res.write_accepted;
    assign o_res.link_mode      = r_res.link_mode;
    assign o_res.rx_level       = r_res.rx_level;
    assign o_res.tx_level       = r_res.tx_level;
    assign o_res.rx_on          = r_res.rx_on;
    assign o_res.tx_on          = r_res.tx_on;

endmodule

### hw/rtl/hduf_checker.sv
// Port-level checker of the serial link controller and its bind to the top level.
`include "half_duplex_uart_fifo_controller_defines.svh"

module hduf_checker import hduf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic [RESULT_W-1:0] i_res_bits
);

    t_result res;
    logic    stalled;
    logic    start_tx;
    logic    abort_tx;

    assign res = t_result'(i_res_bits);
    assign stalled = i_res_valid && !i_res_ready;
    assign start_tx = i_res_valid && (res.start_cmd == CMD_TX);
    assign abort_tx = i_res_valid && (res.abort_cmd == CMD_TX);

    `HDUF_ASSERT_NXT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n, !i_res_valid)
    `HDUF_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, stalled, i_res_valid && $stable(i_res_bits))
    `HDUF_ASSERT_IMP(a_start_tx_mode, i_clk, i_rst_n, start_tx, res.link_mode == MODE_TX)
    `HDUF_ASSERT_IMP(a_abort_tx_mode, i_clk, i_rst_n, abort_tx, res.link_mode != MODE_TX)

endmodule

bind half_duplex_uart_fifo_controller hduf_checker u_hduf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_bits  ({o_res.abort_cmd, o_res.start_cmd, o_res.tx_byte, o_res.read_byte,
                   o_res.read_valid, o_res.write_accepted, o_res.link_mode,
                   o_res.rx_level, o_res.tx_level, o_res.rx_on, o_res.tx_on})
);

### tb/half_duplex_uart_fifo_controller_test.sv
// Self-checking testbench of the half-duplex serial link controller with its byte queues.
module half_duplex_uart_fifo_controller_test;
    import hduf_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_req        req;
        logic [7:0]  data;
        logic        typed;
        t_result     res;
    } t_row;

    localparam t_result ALL_ZERO = '0;

    localparam t_row DIRECTED_ROWS [25] = '{
        '{REQ_READ, 8'h00, 1'b1, ALL_ZERO},
        '{REQ_RX_DONE, 8'hFF, 1'b1, ALL_ZERO},
        '{REQ_TX_DONE, 8'h00, 1'b1, ALL_ZERO},
        '{REQ_TX_OFF, 8'h00, 1'b1, ALL_ZERO},
        '{REQ_RX_OFF, 8'hFF, 1'b1, ALL_ZERO},
        '{REQ_WRITE, 8'h00, 1'b1, '{CMD_NONE, CMD_NONE, 8'h00, 8'h00, 1'b0, 1'b1,
                                    MODE_IDLE, 5'd0, 5'd1, 1'b0, 1'b0}},
        '{REQ_WRITE, 8'hFF, 1'b1, '{CMD_NONE, CMD_NONE, 8'h00, 8'h00, 1'b0, 1'b1,
                                    MODE_IDLE, 5'd0, 5'd2, 1'b0, 1'b0}},
        '{REQ_RX_ON, 8'h00, 1'b1, '{CMD_NONE, CMD_RX, 8'h00, 8'h00, 1'b0, 1'b0,
                                    MODE_RX, 5'd0, 5'd2, 1'b1, 1'b0}},
        '{REQ_RX_DONE, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_RX_DONE, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_TX_ON, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_TX_DONE, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_TX_DONE, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_TX_ON, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_RX_ON, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_WRITE, 8'hA5, 1'b0, ALL_ZERO},
        '{REQ_RX_ON, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_RX_OFF, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_READ, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_READ, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_TX_OFF, 8'hFF, 1'b0, ALL_ZERO},
        '{REQ_TX_ON, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_WRITE, 8'h5A, 1'b0, ALL_ZERO},
        '{REQ_TX_OFF, 8'h00, 1'b0, ALL_ZERO},
        '{REQ_TX_DONE, 8'hFF, 1'b0, ALL_ZERO}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    hduf_req_if req_ch ();
    hduf_res_if res_ch ();

    half_duplex_uart_fifo_controller i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #2 i_clk = ~i_clk;

    t_mode      link_state = MODE_IDLE;
    bit         rx_enable_model = 1'b0;
    bit         tx_enable_model = 1'b0;
    logic [7:0] rx_fifo_model [$];
    logic [7:0] tx_fifo_model [$];

    t_result expected_results [$];
    int      mismatch_count = 0;
    int      stall_cycles = 0;
    bit      gaps_on = 1'b1;
    bit      hold_off_req = 1'b0;
    int      w_line, w_write, w_read, w_toggle;

    function automatic void begin_transmit(inout t_result r);
        tx_enable_model = 1'b1;
        if (link_state != MODE_TX) begin
            if (link_state == MODE_RX) begin
                r.abort_cmd = CMD_RX;
                link_state = MODE_IDLE;
            end
            if (tx_fifo_model.size() != 0) begin
                r.tx_byte = tx_fifo_model.pop_front();
                r.start_cmd = CMD_TX;
                link_state = MODE_TX;
            end
        end
    endfunction

    function automatic t_result predict_link_step(t_req req, logic [7:0] data);
        t_result r;
        r = '0;
        case (req)
            REQ_WRITE: begin
                if (tx_fifo_model.size() < DEPTH) begin
                    tx_fifo_model.push_back(data);
                    r.write_accepted = 1'b1;
                end
                if (tx_enable_model) begin
                    begin_transmit(r);
                end
            end
            REQ_READ: begin
                if (rx_fifo_model.size() != 0) begin
                    r.read_byte = rx_fifo_model.pop_front();
                    r.read_valid = 1'b1;
                end
            end
            REQ_TX_ON: begin
                begin_transmit(r);
            end
            REQ_TX_OFF: begin
                tx_enable_model = 1'b0;
                if (link_state == MODE_TX) begin
                    r.abort_cmd = CMD_TX;
                    link_state = MODE_IDLE;
                end
            end
            REQ_RX_ON: begin
                rx_enable_model = 1'b1;
                if (link_state != MODE_RX) begin
                    if (link_state == MODE_TX) begin
                        r.abort_cmd = CMD_TX;
                    end
                    r.start_cmd = CMD_RX;
                    link_state = MODE_RX;
                end
            end
            REQ_RX_OFF: begin
                rx_enable_model = 1'b0;
                if (link_state == MODE_RX) begin
                    r.abort_cmd = CMD_RX;
                    link_state = MODE_IDLE;
                end
            end
            REQ_RX_DONE: begin
                if (link_state == MODE_RX) begin
                    if (rx_fifo_model.size() < DEPTH) begin
                        rx_fifo_model.push_back(data);
                        r.start_cmd = CMD_RX;
                    end else begin
                        r.abort_cmd = CMD_RX;
                        rx_enable_model = 1'b0;
                        link_state = MODE_IDLE;
                    end
                end
            end
            default: begin
                if (link_state == MODE_TX) begin
                    if (tx_fifo_model.size() != 0) begin
                        r.tx_byte = tx_fifo_model.pop_front();
                        r.start_cmd = CMD_TX;
                    end else if (rx_enable_model && rx_fifo_model.size() < DEPTH) begin
                        r.start_cmd = CMD_RX;
                        link_state = MODE_RX;
                    end else begin
                        link_state = MODE_IDLE;
                    end
                end
            end
        endcase
        r.link_mode = link_state;
        r.rx_level = LEVEL_W'(rx_fifo_model.size());
        r.tx_level = LEVEL_W'(tx_fifo_model.size());
        r.rx_on = rx_enable_model;
        r.tx_on = tx_enable_model;
        return r;
    endfunction

    task automatic issue_request(t_req req, logic [7:0] data, bit typed, t_result typed_res);
        t_result predicted;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= req;
        req_ch.data_in <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = predict_link_step(req, data);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pick_line_item(output t_req req, output logic [7:0] data);
        int roll;
        roll = $urandom_range(0, 7 + w_line + w_write + w_read + w_toggle);
        data = 8'($urandom_range(0, 255));
        if (roll < 8) begin
            req = t_req'($urandom_range(0, 7));
        end else if (roll < 8 + w_line) begin
            case (link_state)
                MODE_RX: req = REQ_RX_DONE;
                MODE_TX: req = REQ_TX_DONE;
                default: req = ($urandom_range(0, 1) != 0) ? REQ_RX_ON : REQ_TX_ON;
            endcase
        end else if (roll < 8 + w_line + w_write) begin
            req = REQ_WRITE;
        end else if (roll < 8 + w_line + w_write + w_read) begin
            req = REQ_READ;
        end else begin
            req = t_req'($urandom_range(REQ_TX_ON, REQ_RX_OFF));
        end
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (res_ch.valid && res_ch.ready) begin
            got = '{res_ch.abort_cmd, res_ch.start_cmd, res_ch.tx_byte, res_ch.read_byte,
                    res_ch.read_valid, res_ch.write_accepted, res_ch.link_mode,
                    res_ch.rx_level, res_ch.tx_level, res_ch.rx_on, res_ch.tx_on};
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none actual %0h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("abort_cmd", want.abort_cmd, got.abort_cmd);
                check_field("start_cmd", want.start_cmd, got.start_cmd);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("write_accepted", want.write_accepted, got.write_accepted);
                check_field("link_mode", want.link_mode, got.link_mode);
                check_field("rx_level", want.rx_level, got.rx_level);
                check_field("tx_level", want.tx_level, got.tx_level);
                check_field("rx_on", want.rx_on, got.rx_on);
                check_field("tx_on", want.tx_on, got.tx_on);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int         p;
        int         k;
        t_req       req;
        logic [7:0] data;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_READ;
        req_ch.data_in <= 8'h00;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(DIRECTED_ROWS); k++) begin
            issue_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].data,
                          DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);
        end

        for (p = 0; p < PHASES; p++) begin
            if (p == 5) begin
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            gaps_on = !(p == 7 || p == PHASES - 1);
            if (p == 2) begin
                hold_off_req = 1'b1;
            end
            w_line = $urandom_range(20, 70);
            w_write = $urandom_range(5, 40);
            w_read = $urandom_range(5, 40);
            w_toggle = $urandom_range(2, 12);
            case ($urandom_range(0, 3))
                0: begin
                    issue_request(REQ_TX_OFF, 8'($urandom_range(0, 255)), 1'b0, ALL_ZERO);
                    repeat (DEPTH + 2) begin
                        issue_request(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0, ALL_ZERO);
                    end
                end
                1: begin
                    issue_request(REQ_RX_ON, 8'($urandom_range(0, 255)), 1'b0, ALL_ZERO);
                    repeat (DEPTH + 2) begin
                        issue_request(REQ_RX_DONE, 8'($urandom_range(0, 255)), 1'b0, ALL_ZERO);
                    end
                end
                default: begin
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick_line_item(req, data);
                issue_request(req, data, 1'b0, ALL_ZERO);
            end
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/hduf_pkg.sv
hw/rtl/hduf_if.sv
hw/rtl/hduf_ram.sv
hw/rtl/hduf_ctrl.sv
hw/rtl/half_duplex_uart_fifo_controller.sv
hw/rtl/hduf_checker.sv
tb/half_duplex_uart_fifo_controller_test.sv
